FILE: rtl/core/isl_pkg.sv
// ============================================================================
// isl_pkg
// Shared types, constants and codes for the indexed shift list block.
// ============================================================================
`default_nettype none

package isl_pkg;

    // Store geometry
    localparam int DEPTH     = 64;
    localparam int WORD_BITS = 32;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);

    // Fixed field widths of the request and result
    localparam int KIND_W    = 3;
    localparam int IDX_W     = 7;
    localparam int VAL_W     = 32;
    localparam int STAT_W    = 2;
    localparam int DATA_W    = 32;
    localparam int FIDX_W    = 6;
    localparam int COUNT_W   = 7;

    // Common width for comparing a request index against the entry count
    localparam int CMP_W     = (IDX_W > CNT_W) ? IDX_W : CNT_W;

    // Stream packing
    localparam int IN_BITS      = IDX_W + VAL_W;
    localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
    localparam int IN_TUSER_W   = KIND_W;
    localparam int OUT_BITS     = STAT_W + DATA_W + 1 + FIDX_W + COUNT_W;
    localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

    // Request kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 3'd0,
        KIND_REMOVE = 3'd1,
        KIND_PUSH   = 3'd2,
        KIND_POP    = 3'd3,
        KIND_SEARCH = 3'd4,
        KIND_READ   = 3'd5,
        KIND_WRITE  = 3'd6,
        KIND_CLEAR  = 3'd7
    } t_kind;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_TAKE_RD,
        S_TAKE_CAP,
        S_SHIFT_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DONE
    } t_state;

    // One request as it enters the sequencer
    typedef struct packed {
        t_kind             kind;
        logic [IDX_W-1:0]  index;
        logic [VAL_W-1:0]  value;
    } t_req;

    // One result as it leaves the sequencer
    typedef struct packed {
        t_status            status;
        logic [DATA_W-1:0]  data_out;
        logic               found;
        logic [FIDX_W-1:0]  found_index;
        logic [CNT_W-1:0]   count;
    } t_rsp;

    // Store access issued by the sequencer
    typedef struct packed {
        logic                  we;
        logic [ADDR_W-1:0]     waddr;
        logic [WORD_BITS-1:0]  wdata;
        logic [ADDR_W-1:0]     raddr;
    } t_ram_cmd;

endpackage

`default_nettype wire

FILE: rtl/core/isl_ram.sv
// ============================================================================
// isl_ram
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
`default_nettype none

module isl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/isl_ctrl.sv
// ============================================================================
// isl_ctrl
// Sequencer for the indexed shift list: checks each request, then moves,
// scans or accesses the stored words one entry at a time through the RAM.
// ============================================================================
`default_nettype none

module isl_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_req_valid,
    input  wire isl_pkg::t_req                 i_req,
    output logic                               o_req_ready,
    output logic                               o_rsp_valid,
    output isl_pkg::t_rsp                      o_rsp,
    input  wire logic                          i_rsp_ready,
    output isl_pkg::t_ram_cmd                  o_ram,
    input  wire logic [isl_pkg::WORD_BITS-1:0] i_ram_rdata
);

    isl_pkg::t_state                   r_state, n_state;
    isl_pkg::t_req                     r_req, n_req;
    logic [isl_pkg::CNT_W-1:0]         r_count, n_count;
    logic [isl_pkg::CNT_W-1:0]         r_ptr, n_ptr;
    logic [isl_pkg::CNT_W-1:0]         r_at, n_at;
    logic                              r_up, n_up;
    isl_pkg::t_status                  r_status, n_status;
    logic [isl_pkg::DATA_W-1:0]        r_data, n_data;
    logic                              r_found, n_found;
    logic [isl_pkg::FIDX_W-1:0]        r_fidx, n_fidx;

    logic [isl_pkg::WORD_BITS-1:0]     word;
    logic [isl_pkg::CMP_W-1:0]         idx_ext, cnt_ext, ins_at, take_at;
    logic                              ins_bad, take_bad, wr_bad, full;
    logic [isl_pkg::CNT_W-1:0]         ptr_dn, ptr_up;
    logic                              more, hit;

    // Request checks and the shared pointer step and compare unit
    always_comb begin
        word    = isl_pkg::WORD_BITS'(r_req.value);
        idx_ext = isl_pkg::CMP_W'(r_req.index);
        cnt_ext = isl_pkg::CMP_W'(r_count);
        ins_at  = (r_req.kind == isl_pkg::KIND_PUSH) ? cnt_ext : idx_ext;
        take_at = (r_req.kind == isl_pkg::KIND_POP) ? (cnt_ext - isl_pkg::CMP_W'(1))
                                                    : idx_ext;
        ins_bad = ins_at > cnt_ext;
        full    = r_count == isl_pkg::CNT_W'(isl_pkg::DEPTH);
        wr_bad  = idx_ext >= cnt_ext;
        take_bad = (r_req.kind == isl_pkg::KIND_POP) ? (r_count == '0) : wr_bad;
        ptr_dn  = r_ptr - isl_pkg::CNT_W'(1);
        ptr_up  = r_ptr + isl_pkg::CNT_W'(1);
        more    = r_up ? (r_ptr > r_at) : (ptr_up < r_count);
        hit     = i_ram_rdata == word;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            isl_pkg::S_IDLE: begin
                if (i_req_valid) begin
                    n_state = isl_pkg::S_EXEC;
                end
            end
            isl_pkg::S_EXEC: begin
                unique case (r_req.kind) inside
                    isl_pkg::KIND_INSERT, isl_pkg::KIND_PUSH: begin
                        n_state = (ins_bad || full) ? isl_pkg::S_DONE : isl_pkg::S_SHIFT_CHK;
                    end
                    isl_pkg::KIND_REMOVE, isl_pkg::KIND_POP, isl_pkg::KIND_READ: begin
                        n_state = take_bad ? isl_pkg::S_DONE : isl_pkg::S_TAKE_RD;
                    end
                    isl_pkg::KIND_SEARCH: begin
                        n_state = isl_pkg::S_SCAN_RD;
                    end
                    default: begin
                        n_state = isl_pkg::S_DONE;
                    end
                endcase
            end
            isl_pkg::S_TAKE_RD: begin
                n_state = isl_pkg::S_TAKE_CAP;
            end
            isl_pkg::S_TAKE_CAP: begin
                n_state = (r_req.kind == isl_pkg::KIND_READ) ? isl_pkg::S_DONE
                                                             : isl_pkg::S_SHIFT_CHK;
            end
            isl_pkg::S_SHIFT_CHK: begin
                if (more) begin
                    n_state = isl_pkg::S_SHIFT_RD;
                end else if (r_up) begin
                    n_state = isl_pkg::S_PUT;
                end else begin
                    n_state = isl_pkg::S_DONE;
                end
            end
            isl_pkg::S_SHIFT_RD: begin
                n_state = isl_pkg::S_SHIFT_WR;
            end
            isl_pkg::S_SHIFT_WR: begin
                n_state = isl_pkg::S_SHIFT_CHK;
            end
            isl_pkg::S_PUT: begin
                n_state = isl_pkg::S_DONE;
            end
            isl_pkg::S_SCAN_RD: begin
                n_state = (r_ptr == '0) ? isl_pkg::S_DONE : isl_pkg::S_SCAN_CMP;
            end
            isl_pkg::S_SCAN_CMP: begin
                n_state = hit ? isl_pkg::S_DONE : isl_pkg::S_SCAN_RD;
            end
            isl_pkg::S_DONE: begin
                if (i_rsp_ready) begin
                    n_state = isl_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = isl_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath updates and RAM accesses for each state
    always_comb begin
        n_req    = r_req;
        n_count  = r_count;
        n_ptr    = r_ptr;
        n_at     = r_at;
        n_up     = r_up;
        n_status = r_status;
        n_data   = r_data;
        n_found  = r_found;
        n_fidx   = r_fidx;
        o_ram.we    = 1'b0;
        o_ram.waddr = r_ptr[isl_pkg::ADDR_W-1:0];
        o_ram.wdata = i_ram_rdata;
        o_ram.raddr = r_at[isl_pkg::ADDR_W-1:0];
        unique case (r_state)
            isl_pkg::S_IDLE: begin
                if (i_req_valid) begin
                    n_req    = i_req;
                    n_status = isl_pkg::STAT_OK;
                    n_data   = '0;
                    n_found  = 1'b0;
                    n_fidx   = '0;
                end
            end
            isl_pkg::S_EXEC: begin
                unique case (r_req.kind) inside
                    isl_pkg::KIND_INSERT, isl_pkg::KIND_PUSH: begin
                        if (ins_bad) begin
                            n_status = isl_pkg::STAT_RANGE;
                        end else if (full) begin
                            n_status = isl_pkg::STAT_FULL;
                        end else begin
                            n_at  = isl_pkg::CNT_W'(ins_at);
                            n_ptr = r_count;
                            n_up  = 1'b1;
                        end
                    end
                    isl_pkg::KIND_REMOVE, isl_pkg::KIND_POP, isl_pkg::KIND_READ: begin
                        if (take_bad) begin
                            n_status = isl_pkg::STAT_RANGE;
                        end else begin
                            n_at = isl_pkg::CNT_W'(take_at);
                        end
                    end
                    isl_pkg::KIND_SEARCH: begin
                        n_ptr = r_count;
                    end
                    isl_pkg::KIND_WRITE: begin
                        if (wr_bad) begin
                            n_status = isl_pkg::STAT_RANGE;
                        end else begin
                            o_ram.we    = 1'b1;
                            o_ram.waddr = isl_pkg::ADDR_W'(idx_ext);
                            o_ram.wdata = word;
                        end
                    end
                    default: begin
                        n_count = '0;
                    end
                endcase
            end
            isl_pkg::S_TAKE_RD: begin
                o_ram.raddr = r_at[isl_pkg::ADDR_W-1:0];
            end
            isl_pkg::S_TAKE_CAP: begin
                n_data = isl_pkg::DATA_W'(i_ram_rdata);
                n_ptr  = r_at;
                n_up   = 1'b0;
            end
            isl_pkg::S_SHIFT_CHK: begin
                // Removal ends here once every later entry has moved down
                if (!more && !r_up) begin
                    n_count = r_count - isl_pkg::CNT_W'(1);
                end
            end
            isl_pkg::S_SHIFT_RD: begin
                o_ram.raddr = r_up ? ptr_dn[isl_pkg::ADDR_W-1:0]
                                   : ptr_up[isl_pkg::ADDR_W-1:0];
            end
            isl_pkg::S_SHIFT_WR: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_ptr[isl_pkg::ADDR_W-1:0];
                o_ram.wdata = i_ram_rdata;
                n_ptr       = r_up ? ptr_dn : ptr_up;
            end
            isl_pkg::S_PUT: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_at[isl_pkg::ADDR_W-1:0];
                o_ram.wdata = word;
                n_count     = r_count + isl_pkg::CNT_W'(1);
            end
            isl_pkg::S_SCAN_RD: begin
                o_ram.raddr = ptr_dn[isl_pkg::ADDR_W-1:0];
            end
            isl_pkg::S_SCAN_CMP: begin
                // Scan runs from the top entry down, so the first hit is the highest
                if (hit) begin
                    n_found = 1'b1;
                    n_fidx  = isl_pkg::FIDX_W'(ptr_dn);
                end else begin
                    n_ptr = ptr_dn;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= isl_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_ptr    <= n_ptr;
        r_at     <= n_at;
        r_up     <= n_up;
        r_status <= n_status;
        r_data   <= n_data;
        r_found  <= n_found;
        r_fidx   <= n_fidx;
    end

    // Handshake and result
    assign o_req_ready       = r_state == isl_pkg::S_IDLE;
    assign o_rsp_valid       = r_state == isl_pkg::S_DONE;
    assign o_rsp.status      = r_status;
    assign o_rsp.data_out    = r_data;
    assign o_rsp.found       = r_found;
    assign o_rsp.found_index = r_fidx;
    assign o_rsp.count       = r_count;

    // The entry count never passes the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= isl_pkg::CNT_W'(isl_pkg::DEPTH))
        else $error("entry count above store depth");

    // Placing the new word grows the list by exactly one
    a_put_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == isl_pkg::S_PUT |=> r_count == $past(r_count) + isl_pkg::CNT_W'(1))
        else $error("insert did not grow the list by one");

    // A search hit always reports an index inside the list
    a_hit_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && r_found) |->
            (isl_pkg::CNT_W'(r_fidx) < r_count && r_status == isl_pkg::STAT_OK))
        else $error("search hit outside the list");

    // The store is never written while idle or holding a result
    a_no_stray_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram.we |-> (r_state != isl_pkg::S_IDLE && r_state != isl_pkg::S_DONE))
        else $error("store written outside a request");

endmodule

`default_nettype wire

FILE: rtl/core/indexed_shift_list.sv
// ============================================================================
// indexed_shift_list
// Ordered list of data words in a RAM with insert, remove, push, pop, search,
// read, write and clear requests.
// ============================================================================
// Usage:
// Requests arrive on the slave stream: tuser carries the kind and tdata the
// index and value. Every request gives exactly one result on the master
// stream with status, removed or read word, search hit and the new count.
// One request is in work at a time; s_axis_tready is high only while the
// sequencer is idle. Insert and push move the later entries up, remove and
// pop move them down, one entry at a time through the single RAM port
// pair; search scans from the top entry down until it hits or runs out.
// The next request can be accepted from the edge at which the previous
// result can first be taken. The result sits in an output register; while
// the receiver stalls the next request is still accepted and worked on,
// and it waits at the end of its work until the register is free. Reset
// empties the list at once; the RAM needs no clearing, as only written
// entries below the count are ever read.
// ============================================================================
`default_nettype none

module indexed_shift_list (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Request stream
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // tdata: index [6:0], value [38:7], zero pad [39]
    input  wire logic [isl_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // tuser: kind [2:0]
    input  wire logic [isl_pkg::IN_TUSER_W-1:0]  i_s_axis_tuser,
    // Result stream
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // tdata: status [1:0], data_out [33:2], found [34], found_index [40:35],
    //        count [47:41]
    output logic      [isl_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);

    isl_pkg::t_req                  req;
    isl_pkg::t_rsp                  rsp;
    isl_pkg::t_ram_cmd              ram_cmd;
    logic [isl_pkg::WORD_BITS-1:0]  ram_rdata;
    logic                           rsp_valid, rsp_ready;
    logic                           r_out_valid;
    isl_pkg::t_rsp                  r_out;

    // Unpack the request
    always_comb begin
        req.kind  = isl_pkg::t_kind'(i_s_axis_tuser);
        req.index = i_s_axis_tdata[isl_pkg::IDX_W-1:0];
        req.value = i_s_axis_tdata[isl_pkg::IN_BITS-1:isl_pkg::IDX_W];
    end

    isl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_axis_tvalid),
        .i_req       (req),
        .o_req_ready (o_s_axis_tready),
        .o_rsp_valid (rsp_valid),
        .o_rsp       (rsp),
        .i_rsp_ready (rsp_ready),
        .o_ram       (ram_cmd),
        .i_ram_rdata (ram_rdata)
    );

    isl_ram #(
        .WIDTH (isl_pkg::WORD_BITS),
        .DEPTH (isl_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_cmd.we),
        .i_waddr (ram_cmd.waddr),
        .i_wdata (ram_cmd.wdata),
        .i_raddr (ram_cmd.raddr),
        .o_rdata (ram_rdata)
    );

    // Output register: takes a result whenever it is empty or being drained
    assign rsp_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rsp_ready) begin
            r_out_valid <= rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rsp_valid && rsp_ready) begin
            r_out <= rsp;
        end
    end

    // Pack the result
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = isl_pkg::OUT_TDATA_W'({
        isl_pkg::COUNT_W'(r_out.count),
        r_out.found_index,
        r_out.found,
        r_out.data_out,
        r_out.status
    });

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking testbench for the indexed shift list. Requests go in on the
// slave stream and every result is checked on the master stream. A predictor
// in the testbench keeps its own copy of the list and computes the expected
// status, word, search hit and count for every accepted request. The tests
// run a directed sequence, a fill to the full store, a long receiver stall
// and a random mix that moves the list through its whole range.
// ============================================================================

module tb_top;

    // Clock, reset and stream signals
    logic                            i_clk;
    logic                            i_rst_n         = 1'b0;
    logic                            i_s_axis_tvalid = 1'b0;
    logic                            o_s_axis_tready;
    // tdata: index [6:0], value [38:7], zero pad [39]
    logic [isl_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata  = '0;
    // tuser: kind [2:0]
    logic [isl_pkg::IN_TUSER_W-1:0]  i_s_axis_tuser  = '0;
    logic                            o_m_axis_tvalid;
    logic                            i_m_axis_tready = 1'b0;
    // tdata: status [1:0], data_out [33:2], found [34], found_index [40:35],
    //        count [47:41]
    logic [isl_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata;

    // Predicted list contents and length
    logic [isl_pkg::WORD_BITS-1:0]   list_words [isl_pkg::DEPTH];
    int unsigned                     list_len = 0;

    // Results still owed by the block, oldest first
    isl_pkg::t_rsp                   expected_results [$];
    int                              mismatch_count = 0;

    // Idling limits of each side, and a one-off long stall for the receiver
    int                              tx_gap_max  = 0;
    int                              rx_wait_max = 0;
    int                              rx_hold_req = 0;

    indexed_shift_list i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Applies one request to the predicted list and returns its result.
    function automatic isl_pkg::t_rsp apply_request(isl_pkg::t_kind kind,
                                                    logic [isl_pkg::IDX_W-1:0] idx,
                                                    logic [isl_pkg::VAL_W-1:0] val);
        isl_pkg::t_rsp r;
        int unsigned   at;
        int            i;
        r        = '0;
        r.status = isl_pkg::STAT_OK;
        case (kind) inside
            isl_pkg::KIND_INSERT, isl_pkg::KIND_PUSH: begin
                at = (kind == isl_pkg::KIND_PUSH) ? list_len : int'(idx);
                // The index check comes before the full check.
                if (at > list_len) begin
                    r.status = isl_pkg::STAT_RANGE;
                end else if (list_len >= isl_pkg::DEPTH) begin
                    r.status = isl_pkg::STAT_FULL;
                end else begin
                    for (i = list_len; i > at; i--) list_words[i] = list_words[i-1];
                    list_words[at] = val;
                    list_len++;
                end
            end
            isl_pkg::KIND_REMOVE, isl_pkg::KIND_POP: begin
                at = (kind == isl_pkg::KIND_POP) ? list_len - 1 : int'(idx);
                if (list_len == 0 || at >= list_len) begin
                    r.status = isl_pkg::STAT_RANGE;
                end else begin
                    r.data_out = list_words[at];
                    for (i = at; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
                    list_len--;
                end
            end
            isl_pkg::KIND_SEARCH: begin
                // The highest matching index wins.
                for (i = list_len - 1; i >= 0; i--) begin
                    if (list_words[i] == val) begin
                        r.found       = 1'b1;
                        r.found_index = i[isl_pkg::FIDX_W-1:0];
                        break;
                    end
                end
            end
            isl_pkg::KIND_READ: begin
                if (int'(idx) >= list_len) r.status = isl_pkg::STAT_RANGE;
                else r.data_out = list_words[idx[isl_pkg::ADDR_W-1:0]];
            end
            isl_pkg::KIND_WRITE: begin
                if (int'(idx) >= list_len) r.status = isl_pkg::STAT_RANGE;
                else list_words[idx[isl_pkg::ADDR_W-1:0]] = val;
            end
            default: begin
                list_len = 0;
            end
        endcase
        r.count = list_len[isl_pkg::CNT_W-1:0];
        return r;
    endfunction

    // Offers one request after a random gap and waits until it is taken.
    // Called just after a rising edge; tvalid gets one assignment per edge.
    task automatic send_request(isl_pkg::t_kind kind, logic [isl_pkg::IDX_W-1:0] idx,
                                logic [isl_pkg::VAL_W-1:0] val);
        int gap;
        gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {1'b0, val, idx};
        i_s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!o_s_axis_tready);
        expected_results.push_back(apply_request(kind, idx, val));
    endtask

    // Receiver: waits a drawn number of cycles before each result, or the
    // long stall when one has been asked for.
    initial begin : result_receiver
        int w;
        forever begin
            if (rx_hold_req > 0) begin
                w           = rx_hold_req;
                rx_hold_req = 0;
            end else begin
                w = (rx_wait_max == 0) ? 0 : $urandom_range(0, rx_wait_max);
            end
            if (w > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(i_rst_n && o_m_axis_tvalid));
        end
    end

    // Compares every accepted result with the oldest expectation.
    always @(posedge i_clk) begin : result_checker
        isl_pkg::t_rsp want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result with no request waiting, expected none, got %h",
                         $time, o_m_axis_tdata);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_m_axis_tdata[1:0] != want.status) begin
                    $display("%0t: status expected %0d, got %0d",
                             $time, want.status, o_m_axis_tdata[1:0]);
                    mismatch_count++;
                end
                if (o_m_axis_tdata[33:2] != want.data_out) begin
                    $display("%0t: data_out expected %h, got %h",
                             $time, want.data_out, o_m_axis_tdata[33:2]);
                    mismatch_count++;
                end
                if (o_m_axis_tdata[34] != want.found) begin
                    $display("%0t: found expected %0d, got %0d",
                             $time, want.found, o_m_axis_tdata[34]);
                    mismatch_count++;
                end
                if (o_m_axis_tdata[40:35] != want.found_index) begin
                    $display("%0t: found_index expected %0d, got %0d",
                             $time, want.found_index, o_m_axis_tdata[40:35]);
                    mismatch_count++;
                end
                if (o_m_axis_tdata[47:41] != want.count) begin
                    $display("%0t: count expected %0d, got %0d",
                             $time, want.count, o_m_axis_tdata[47:41]);
                    mismatch_count++;
                end
            end
        end
    end

    // Empty-list errors, edge indexes, duplicate search and clear.
    task automatic test_directed();
        tx_gap_max  = 3;
        rx_wait_max = 3;
        send_request(isl_pkg::KIND_POP,    7'd0,  32'h0000_0000);
        send_request(isl_pkg::KIND_REMOVE, 7'd0,  32'h0000_0000);
        send_request(isl_pkg::KIND_READ,   7'd0,  32'h0000_0000);
        send_request(isl_pkg::KIND_WRITE,  7'd0,  32'h1357_9BDF);
        send_request(isl_pkg::KIND_SEARCH, 7'd0,  32'h0000_0000);
        // Insert past the end of an empty list is refused.
        send_request(isl_pkg::KIND_INSERT, 7'd1,  32'h0000_0001);
        send_request(isl_pkg::KIND_INSERT, 7'd0,  32'h0000_0000);
        send_request(isl_pkg::KIND_PUSH,   7'd0,  32'hFFFF_FFFF);
        send_request(isl_pkg::KIND_INSERT, 7'd2,  32'hA5A5_A5A5);
        send_request(isl_pkg::KIND_INSERT, 7'd1,  32'h5A5A_5A5A);
        send_request(isl_pkg::KIND_PUSH,   7'd0,  32'h0000_0000);
        // Zero sits at both ends; the higher index must be reported.
        send_request(isl_pkg::KIND_SEARCH, 7'd0,  32'h0000_0000);
        send_request(isl_pkg::KIND_SEARCH, 7'd0,  32'h1234_5678);
        send_request(isl_pkg::KIND_READ,   7'd3,  32'h0000_0000);
        send_request(isl_pkg::KIND_READ,   7'd5,  32'h0000_0000);
        send_request(isl_pkg::KIND_READ,   7'd64, 32'h0000_0000);
        send_request(isl_pkg::KIND_WRITE,  7'd2,  32'h8000_0001);
        send_request(isl_pkg::KIND_WRITE,  7'd5,  32'h8000_0001);
        send_request(isl_pkg::KIND_REMOVE, 7'd1,  32'h0000_0000);
        send_request(isl_pkg::KIND_REMOVE, 7'd4,  32'h0000_0000);
        send_request(isl_pkg::KIND_POP,    7'd0,  32'h0000_0000);
        // A bad index is reported ahead of any other check.
        send_request(isl_pkg::KIND_INSERT, 7'd64, 32'h0000_0002);
        send_request(isl_pkg::KIND_CLEAR,  7'd0,  32'h0000_0000);
        send_request(isl_pkg::KIND_READ,   7'd0,  32'h0000_0000);
        send_request(isl_pkg::KIND_POP,    7'd0,  32'h0000_0000);
    endtask

    // Fills the store to its depth and works at the top entry.
    task automatic test_full_store();
        int k;
        tx_gap_max  = 0;
        rx_wait_max = 0;
        send_request(isl_pkg::KIND_CLEAR, 7'd0, 32'h0000_0000);
        for (k = 0; k < isl_pkg::DEPTH; k++) begin
            if (k % 3 == 2)
                send_request(isl_pkg::KIND_INSERT, 7'($urandom_range(0, list_len)),
                             $urandom);
            else
                send_request(isl_pkg::KIND_PUSH, 7'd0, 32'h4000_0000 + k);
        end
        tx_gap_max  = 17;
        rx_wait_max = 17;
        send_request(isl_pkg::KIND_PUSH,   7'd0,  32'h0F0F_0F0F);
        send_request(isl_pkg::KIND_INSERT, 7'd64, 32'h0F0F_0F0F);
        send_request(isl_pkg::KIND_INSERT, 7'd0,  32'h0F0F_0F0F);
        send_request(isl_pkg::KIND_SEARCH, 7'd0,  list_words[isl_pkg::DEPTH-1]);
        send_request(isl_pkg::KIND_READ,   7'd63, 32'h0000_0000);
        send_request(isl_pkg::KIND_WRITE,  7'd63, 32'hFFFF_FFFF);
        send_request(isl_pkg::KIND_SEARCH, 7'd0,  32'hFFFF_FFFF);
        send_request(isl_pkg::KIND_REMOVE, 7'd0,  32'h0000_0000);
        send_request(isl_pkg::KIND_INSERT, 7'd0,  32'h7FFF_FFFE);
        send_request(isl_pkg::KIND_REMOVE, 7'd63, 32'h0000_0000);
        send_request(isl_pkg::KIND_POP,    7'd0,  32'h0000_0000);
        send_request(isl_pkg::KIND_CLEAR,  7'd0,  32'h0000_0000);
    endtask

    // The receiver stalls for a long stretch while requests keep coming.
    task automatic test_receiver_stall();
        int k;
        tx_gap_max  = 0;
        rx_wait_max = 0;
        rx_hold_req = 400;
        for (k = 0; k < 16; k++) begin
            if (k % 4 == 3)
                send_request(isl_pkg::KIND_READ, 7'($urandom_range(0, list_len)), 32'h0);
            else
                send_request(isl_pkg::KIND_PUSH, 7'd0, $urandom);
        end
    endtask

    // Random mix: the list swings between empty and full, most requests are
    // well formed and searches look for a held word about a third of the time.
    task automatic test_random_mix(int n);
        int                        k;
        int                        roll;
        bit                        grow;
        isl_pkg::t_kind            kind;
        logic [isl_pkg::IDX_W-1:0] idx;
        logic [isl_pkg::VAL_W-1:0] val;
        grow = 1'b1;
        for (k = 0; k < n; k++) begin
            if (k % 150 == 0) begin
                tx_gap_max  = ($urandom_range(0, 2) == 0) ? 0 : 17;
                rx_wait_max = ($urandom_range(0, 2) == 0) ? 0 : 17;
            end
            if (list_len == 0) grow = 1'b1;
            else if (list_len == isl_pkg::DEPTH && $urandom_range(0, 3) == 0) grow = 1'b0;
            else if ($urandom_range(0, 199) == 0) grow = ~grow;

            roll = $urandom_range(0, 199);
            if (roll == 199) begin
                kind = isl_pkg::KIND_CLEAR;
            end else begin
                roll = roll / 2;
                if (roll >= 88)      kind = isl_pkg::KIND_WRITE;
                else if (roll >= 78) kind = isl_pkg::KIND_READ;
                else if (roll >= 63) kind = isl_pkg::KIND_SEARCH;
                else if (grow) begin
                    if (roll < 30)      kind = isl_pkg::KIND_INSERT;
                    else if (roll < 50) kind = isl_pkg::KIND_PUSH;
                    else if (roll < 58) kind = isl_pkg::KIND_REMOVE;
                    else                kind = isl_pkg::KIND_POP;
                end else begin
                    if (roll < 10)      kind = isl_pkg::KIND_INSERT;
                    else if (roll < 18) kind = isl_pkg::KIND_PUSH;
                    else if (roll < 43) kind = isl_pkg::KIND_REMOVE;
                    else                kind = isl_pkg::KIND_POP;
                end
            end

            if ($urandom_range(0, 99) < 15)
                idx = 7'($urandom_range(0, 64));
            else if (kind == isl_pkg::KIND_INSERT)
                idx = 7'($urandom_range(0, list_len));
            else
                idx = (list_len == 0) ? 7'd0 : 7'($urandom_range(0, list_len - 1));

            roll = $urandom_range(0, 99);
            if (roll < 35 && list_len != 0)
                val = list_words[$urandom_range(0, list_len - 1)];
            else if (roll < 70)
                val = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 7))
                                                  : ~32'($urandom_range(0, 7));
            else
                val = $urandom;

            send_request(kind, idx, val);
        end
    endtask

    // Reset, the tests in turn, then the drain and the verdict.
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_store();
        test_receiver_stall();
        test_random_mix(1300);

        i_s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: indexed_shift_list.f
rtl/core/isl_pkg.sv
rtl/core/isl_ram.sv
rtl/core/isl_ctrl.sv
rtl/core/indexed_shift_list.sv
tb/sv/tb_top.sv
